FILE: rtl/wei_pkg.sv
// Shared types and constants for the wavefield extrapolation and imaging core.
package wei_pkg;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_TAP     = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [1:0] CSR_NUM_FREQS  = 2'd0;
   localparam logic [1:0] CSR_NUM_X      = 2'd1;
   localparam logic [1:0] CSR_HALF_WIDTH = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         freq_index;
      logic [8:0]         x_index;
      logic signed [31:0] fwd_re;
      logic signed [31:0] fwd_im;
      logic signed [31:0] bwd_re;
      logic signed [31:0] bwd_im;
   } item_type;

   typedef struct packed {
      logic               result_kind;
      logic [8:0]         x_position;
      logic signed [47:0] image_value;
      logic signed [31:0] out_fwd_re;
      logic signed [31:0] out_fwd_im;
      logic signed [31:0] out_bwd_re;
      logic signed [31:0] out_bwd_im;
      logic               row_last;
   } result_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture item into input register
      logic wr_load;    // write sample into current bank
      logic rd_issue;   // issue bank read (readback or tap operand)
      logic mac;        // multiply stage valid
      logic acc;        // accumulate stage valid
      logic finish;     // advance tap; on last tap write new sample, update image
      logic img_rd;     // read image accumulator
      logic emit;       // load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tap;
      logic is_load;
      logic is_read;
      logic in_range;   // tap position inside 0..nx-1
      logic last_tap;
      logic last_freq;
   } stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647)       sat32 = 32'sh7fffffff;
      else if (v < -35'sd2147483648) sat32 = 32'sh80000000;
      else                           sat32 = v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'sd140737488355327)       sat48 = 48'sh7fffffffffff;
      else if (v < -50'sd140737488355328) sat48 = 48'sh800000000000;
      else                                sat48 = v[47:0];
   endfunction

endpackage

FILE: rtl/wei_ctrl.sv
// Sequencing state machine for the wavefield extrapolation and imaging core.
module wei_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output wei_pkg::cmd_type  cmd,
   input  wei_pkg::stat_type stat
);
   import wei_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_READ, S_MUL, S_ACC, S_FIN, S_IMG, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_load) begin
               cmd.wr_load = 1'b1;
               state_in    = S_IDLE;
            end else if (stat.is_read || stat.is_tap) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            if (stat.is_read) state_in = S_EMIT;
            else begin
               cmd.mac  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.acc  = stat.in_range;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (stat.last_tap) begin
               cmd.img_rd = 1'b1;
               state_in   = S_FIN;
            end else begin
               cmd.finish = 1'b0;
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.last_tap) begin
               cmd.finish = 1'b1;
               state_in   = stat.last_freq ? S_IMG : S_IDLE;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_IMG:  state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/wei_datapath.sv
// Wavefield banks, complex MAC, image accumulator and counters.
module wei_datapath #(
   parameter int NF_MAX = 256,
   parameter int NX_MAX = 512,
   parameter int M_MAX  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  wei_pkg::item_type  item,
   input  wei_pkg::cmd_type   cmd,
   output wei_pkg::stat_type  stat,
   input  logic [8:0]         num_freqs,
   input  logic [9:0]         num_x,
   input  logic [5:0]         half_width,
   output wei_pkg::result_type result
);
   import wei_pkg::*;

   localparam int FW    = (NF_MAX > 1) ? $clog2(NF_MAX) : 1;
   localparam int XW    = (NX_MAX > 1) ? $clog2(NX_MAX) : 1;
   localparam int AW    = 1 + FW + XW;
   localparam int DEPTH = 2 ** AW;

   function automatic logic signed [34:0] r30(input logic signed [63:0] p);
      logic signed [63:0] q;
      q = (p + 64'sd536870912) >>> 30;
      r30 = 35'(q);
   endfunction

   item_type           item_ff;
   logic [127:0]       fwd_mem [DEPTH];
   logic [127:0]       rd_ff;
   logic [47:0]        img_mem [NX_MAX];
   logic signed [47:0] img_rd_ff;
   logic signed [47:0] img_out_ff;
   logic [8:0]         loc_out_ff;
   logic               row_last_ff;
   logic signed [63:0] p_ff [8];
   logic signed [31:0] sum_ff [4];
   logic               bank_ff;
   logic [FW-1:0]      freq_ff;
   logic [XW-1:0]      loc_ff;
   logic [6:0]         tap_ff;
   logic               addr_ok_ff;

   logic [13:0]        nf_eff, nx_eff;
   logic [5:0]         m_eff;
   logic signed [15:0] pos;
   logic               pos_ok, ld_ok, loc_last;
   logic [AW-1:0]      ld_addr, tap_addr, new_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [127:0]       mem_wd;
   logic signed [63:0] term_a, term_b;
   logic signed [49:0] term, img_next;
   logic signed [31:0] pr_f, pi_f, pr_b, pi_b;
   result_type         rsp_in;

   always_comb begin
      nf_eff = (num_freqs == 9'd0) ? 14'd1 :
               ((14'(num_freqs) > 14'(NF_MAX)) ? 14'(NF_MAX) : 14'(num_freqs));
      nx_eff = (num_x == 10'd0) ? 14'd1 :
               ((14'(num_x) > 14'(NX_MAX)) ? 14'(NX_MAX) : 14'(num_x));
      m_eff  = (half_width > 6'(M_MAX)) ? 6'(M_MAX) : half_width;
      pos    = 16'(loc_ff) + 16'(tap_ff) - 16'(m_eff);
      pos_ok = (pos >= 16'sd0) && (pos < $signed({2'b0, nx_eff}));
      ld_ok  = (14'(item_ff.freq_index) < 14'(NF_MAX)) &&
               (14'(item_ff.x_index) < 14'(NX_MAX));
      loc_last = (14'(loc_ff) + 14'd1 >= nx_eff);
      ld_addr  = {bank_ff, FW'(item_ff.freq_index), XW'(item_ff.x_index)};
      tap_addr = {bank_ff, freq_ff, XW'(pos)};
      new_addr = {~bank_ff, freq_ff, loc_ff};
      stat.is_tap    = (item_ff.kind == KIND_TAP);
      stat.is_load   = (item_ff.kind == KIND_LOAD);
      stat.is_read   = (item_ff.kind == KIND_READ);
      stat.in_range  = pos_ok;
      stat.last_tap  = ({1'b0, tap_ff} >= {1'b0, m_eff, 1'b0});
      stat.last_freq = (14'(freq_ff) + 14'd1 >= nf_eff);
      mem_we = (cmd.wr_load && ld_ok) || (cmd.finish && stat.last_tap);
      mem_wa = cmd.wr_load ? ld_addr : new_addr;
      mem_wd = cmd.wr_load ?
               {item_ff.fwd_re, item_ff.fwd_im, item_ff.bwd_re, item_ff.bwd_im} :
               {sum_ff[0], sum_ff[1], sum_ff[2], sum_ff[3]};
      term_a   = 64'(sum_ff[0]) * 64'(sum_ff[2]) + 64'sd16384;
      term_b   = 64'(sum_ff[1]) * 64'(sum_ff[3]) + 64'sd16384;
      term     = 50'(term_a >>> 15) + 50'(term_b >>> 15);
      img_next = (freq_ff == '0) ? term : 50'(img_rd_ff) + term;
      pr_f = sat32(r30(p_ff[0]) - r30(p_ff[1]));
      pi_f = sat32(r30(p_ff[2]) + r30(p_ff[3]));
      pr_b = sat32(r30(p_ff[4]) - r30(p_ff[5]));
      pi_b = sat32(r30(p_ff[6]) + r30(p_ff[7]));
      rsp_in = '0;
      if (item_ff.kind == KIND_READ) begin
         rsp_in.result_kind = 1'b1;
         rsp_in.x_position  = item_ff.x_index;
         if (addr_ok_ff) begin
            rsp_in.out_fwd_re = rd_ff[127:96];
            rsp_in.out_fwd_im = rd_ff[95:64];
            rsp_in.out_bwd_re = rd_ff[63:32];
            rsp_in.out_bwd_im = rd_ff[31:0];
         end
      end else begin
         rsp_in.x_position  = loc_out_ff;
         rsp_in.image_value = img_out_ff;
         rsp_in.row_last    = row_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= item;
      if (mem_we) fwd_mem[mem_wa] <= mem_wd;
      if (cmd.rd_issue) begin
         rd_ff      <= fwd_mem[stat.is_read ? ld_addr : tap_addr];
         addr_ok_ff <= ld_ok;
      end
      if (cmd.mac) begin
         p_ff[0] <= 64'(item_ff.fwd_re) * 64'($signed(rd_ff[127:96]));
         p_ff[1] <= 64'(item_ff.fwd_im) * 64'($signed(rd_ff[95:64]));
         p_ff[2] <= 64'(item_ff.fwd_re) * 64'($signed(rd_ff[95:64]));
         p_ff[3] <= 64'(item_ff.fwd_im) * 64'($signed(rd_ff[127:96]));
         p_ff[4] <= 64'(item_ff.bwd_re) * 64'($signed(rd_ff[63:32]));
         p_ff[5] <= 64'(item_ff.bwd_im) * 64'($signed(rd_ff[31:0]));
         p_ff[6] <= 64'(item_ff.bwd_re) * 64'($signed(rd_ff[31:0]));
         p_ff[7] <= 64'(item_ff.bwd_im) * 64'($signed(rd_ff[63:32]));
      end
      if (cmd.img_rd) img_rd_ff <= $signed(img_mem[loc_ff]);
      if (cmd.finish && stat.last_tap) begin
         img_mem[loc_ff] <= sat48(img_next);
         img_out_ff      <= sat48(img_next);
         loc_out_ff      <= 9'(loc_ff);
         row_last_ff     <= loc_last;
      end
      if (cmd.emit) result <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         freq_ff <= '0;
         loc_ff  <= '0;
         tap_ff  <= '0;
         for (int k = 0; k < 4; k++) sum_ff[k] <= '0;
      end else begin
         if (cmd.acc) begin
            sum_ff[0] <= sat32(35'(sum_ff[0]) + 35'(pr_f));
            sum_ff[1] <= sat32(35'(sum_ff[1]) + 35'(pi_f));
            sum_ff[2] <= sat32(35'(sum_ff[2]) + 35'(pr_b));
            sum_ff[3] <= sat32(35'(sum_ff[3]) + 35'(pi_b));
         end
         if (cmd.finish) begin
            if (stat.last_tap) begin
               for (int k = 0; k < 4; k++) sum_ff[k] <= '0;
               tap_ff <= '0;
               if (loc_last) begin
                  loc_ff <= '0;
                  if (stat.last_freq) begin
                     freq_ff <= '0;
                     bank_ff <= ~bank_ff;
                  end else freq_ff <= freq_ff + FW'(1);
               end else loc_ff <= loc_ff + XW'(1);
            end else tap_ff <= tap_ff + 7'd1;
         end
      end
   end

endmodule

FILE: rtl/wavefield_extrapolate_image_core.sv
// Top level of the wavefield extrapolation and imaging core.
// Items are handled one at a time: a load or an ignored item passes the idle and
// decode states, a readback also read and emit, an operator tap read, multiply,
// accumulate and finish, and the last tap of a location in the last slice also
// image and emit, as it also emits an image sample. A result waits in the output
// register; the next result holds the core in its emit state until that register
// is taken. Each bank access is a registered read or a write, one per cycle.
module wavefield_extrapolate_image_core #(
   parameter int NF_MAX = 256,
   parameter int NX_MAX = 512,
   parameter int M_MAX  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,  // freq_index, x_index, fwd_re, fwd_im, bwd_re, bwd_im
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // x_position, image_value, out_fwd_re, out_fwd_im, out_bwd_re, out_bwd_im
   output logic [191:0] rsp_tdata,
   output logic         rsp_tuser,  // result_kind
   output logic         rsp_tlast,  // row_last
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import wei_pkg::*;

   item_type   item;
   result_type result;
   cmd_type    cmd;
   stat_type   stat;
   logic [8:0] num_freqs_ff;
   logic [9:0] num_x_ff;
   logic [5:0] half_width_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_freqs_ff  <= 9'd1;
         num_x_ff      <= 10'd1;
         half_width_ff <= 6'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_FREQS:  num_freqs_ff  <= csr_data[8:0];
            CSR_NUM_X:      num_x_ff      <= csr_data[9:0];
            CSR_HALF_WIDTH: half_width_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   assign item.kind       = req_tuser;
   assign item.freq_index = req_tdata[7:0];
   assign item.x_index    = req_tdata[16:8];
   assign item.fwd_re     = req_tdata[48:17];
   assign item.fwd_im     = req_tdata[80:49];
   assign item.bwd_re     = req_tdata[112:81];
   assign item.bwd_im     = req_tdata[144:113];

   wei_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .cmd(cmd), .stat(stat)
   );

   wei_datapath #(.NF_MAX(NF_MAX), .NX_MAX(NX_MAX), .M_MAX(M_MAX)) u_dp (
      .clock(clock), .reset(reset), .item(item), .cmd(cmd), .stat(stat),
      .num_freqs(num_freqs_ff), .num_x(num_x_ff), .half_width(half_width_ff),
      .result(result)
   );

   assign rsp_tuser = result.result_kind;
   assign rsp_tlast = result.row_last;
   assign rsp_tdata = {7'd0, result.out_bwd_im, result.out_bwd_re, result.out_fwd_im,
                       result.out_fwd_re, result.image_value, result.x_position};
endmodule

FILE: sim/wei_checker.sv
// Predictor and scoreboard for the wavefield extrapolation and imaging core.
module wei_checker
   import wei_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [151:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [191:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   localparam int NF_LIM = 256;
   localparam int NX_LIM = 512;
   localparam int M_LIM  = 32;

   typedef struct {
      int fr;
      int fi;
      int br;
      int bi;
   } sample_type;

   sample_type field_mem[int];
   longint     image_acc[int];
   result_type expected_q[$];
   logic [8:0] cfg_nf;
   logic [9:0] cfg_nx;
   logic [5:0] cfg_m;
   bit         bank;
   int         freq_cnt, loc_cnt, tap_cnt;
   int         sums[4];

   assign pending = expected_q.size();

   function automatic int key(bit b, int f, int x);
      return int'(b) * 131072 + f * 512 + x;
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint round30(int a, int b);
      return (longint'(a) * longint'(b) + (longint'(1) <<< 29)) >>> 30;
   endfunction

   function automatic longint round15(int a, int b);
      return (longint'(a) * longint'(b) + (longint'(1) <<< 14)) >>> 15;
   endfunction

   // sums[base], sums[base+1] += coef * sample
   task automatic complex_mac(int base, int cr, int ci, int sr, int si);
      longint pr, pi;
      pr = clamp(round30(cr, sr) - round30(ci, si), 32);
      pi = clamp(round30(cr, si) + round30(ci, sr), 32);
      sums[base]     = int'(clamp(longint'(sums[base]) + pr, 32));
      sums[base + 1] = int'(clamp(longint'(sums[base + 1]) + pi, 32));
   endtask

   task automatic predict_item(item_type it);
      result_type r;
      sample_type s;
      int         nf, nx, m, pos, j, i;
      longint     term;
      r = '0;
      case (it.kind)
         KIND_LOAD: begin
            s.fr = it.fwd_re; s.fi = it.fwd_im; s.br = it.bwd_re; s.bi = it.bwd_im;
            field_mem[key(bank, it.freq_index, it.x_index)] = s;
         end
         KIND_READ: begin
            r.result_kind = 1'b1;
            r.x_position  = it.x_index;
            if (field_mem.exists(key(bank, it.freq_index, it.x_index))) begin
               s = field_mem[key(bank, it.freq_index, it.x_index)];
               r.out_fwd_re = s.fr; r.out_fwd_im = s.fi;
               r.out_bwd_re = s.br; r.out_bwd_im = s.bi;
            end
            expected_q.push_back(r);
         end
         KIND_TAP: begin
            nf = (cfg_nf == 0) ? 1 : ((cfg_nf > NF_LIM) ? NF_LIM : int'(cfg_nf));
            nx = (cfg_nx == 0) ? 1 : ((cfg_nx > NX_LIM) ? NX_LIM : int'(cfg_nx));
            m  = (cfg_m > M_LIM) ? M_LIM : int'(cfg_m);
            j = freq_cnt % NF_LIM;
            i = loc_cnt % NX_LIM;
            pos = i + tap_cnt - m;
            if (pos >= 0 && pos < nx) begin
               s = field_mem[key(bank, j, pos)];
               complex_mac(0, it.fwd_re, it.fwd_im, s.fr, s.fi);
               complex_mac(2, it.bwd_re, it.bwd_im, s.br, s.bi);
            end
            if (tap_cnt >= 2 * m) begin
               s.fr = sums[0]; s.fi = sums[1]; s.br = sums[2]; s.bi = sums[3];
               field_mem[key(!bank, j, i)] = s;
               term = round15(sums[0], sums[2]) + round15(sums[1], sums[3]);
               if (j == 0) image_acc[i] = clamp(term, 48);
               else        image_acc[i] = clamp(image_acc[i] + term, 48);
               sums = '{0, 0, 0, 0};
               tap_cnt = 0;
               if (j + 1 >= nf) begin
                  r.x_position  = i;
                  r.image_value = image_acc[i][47:0];
                  r.row_last    = (i + 1 >= nx);
                  expected_q.push_back(r);
               end
               if (i + 1 >= nx) begin
                  loc_cnt = 0;
                  if (j + 1 >= nf) begin
                     freq_cnt = 0;
                     bank = !bank;
                  end else begin
                     freq_cnt = j + 1;
                  end
               end else begin
                  loc_cnt = i + 1;
               end
            end else begin
               tap_cnt = (tap_cnt + 1) & 'h7f;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string name, longint expv, longint actv);
      if (expv != actv) begin
         $error("%s: expected %0d, got %0d", name, expv, actv);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      item_type   it;
      result_type e;
      if (reset) begin
         cfg_nf = 1; cfg_nx = 1; cfg_m = 0;
         bank = 0; freq_cnt = 0; loc_cnt = 0; tap_cnt = 0;
         sums = '{0, 0, 0, 0};
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_FREQS:  cfg_nf = csr_data[8:0];
               CSR_NUM_X:      cfg_nx = csr_data[9:0];
               CSR_HALF_WIDTH: cfg_m  = csr_data[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.kind       = req_tuser;
            it.freq_index = req_tdata[7:0];
            it.x_index    = req_tdata[16:8];
            it.fwd_re     = req_tdata[48:17];
            it.fwd_im     = req_tdata[80:49];
            it.bwd_re     = req_tdata[112:81];
            it.bwd_im     = req_tdata[144:113];
            predict_item(it);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("result_kind: expected no result, got %0d", rsp_tuser);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               check_field("result_kind", e.result_kind, rsp_tuser);
               check_field("x_position", e.x_position, rsp_tdata[8:0]);
               check_field("image_value", e.image_value, $signed(rsp_tdata[56:9]));
               check_field("out_fwd_re", e.out_fwd_re, $signed(rsp_tdata[88:57]));
               check_field("out_fwd_im", e.out_fwd_im, $signed(rsp_tdata[120:89]));
               check_field("out_bwd_re", e.out_bwd_re, $signed(rsp_tdata[152:121]));
               check_field("out_bwd_im", e.out_bwd_im, $signed(rsp_tdata[184:153]));
               check_field("row_last", e.row_last, rsp_tlast);
            end
         end
      end
   end

endmodule

FILE: sim/tb.sv
// Stimulus, clocking and verdict for the wavefield extrapolation and imaging core.
module tb;
   import wei_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;
   int           fail_count, pending;
   int           send_pct = 7, recv_pct = 75;
   int           item_cnt = 0, stall_cycles = 0;

   wavefield_extrapolate_image_core DUT (.*);
   wei_checker u_checker (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [31:0] sample_value();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2, 3, 4: return $urandom();
         default: return $signed($urandom_range(2 ** 26)) - (2 ** 25);
      endcase
   endfunction

   task automatic send(logic [1:0] kind, int f, int x,
                       logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
      while ($urandom_range(99) < send_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {7'b0, d, c, b, a, x[8:0], f[7:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      item_cnt++;
      if (item_cnt == 600) begin
         send_pct = 75; recv_pct = 7;
      end else if (item_cnt == 1200) begin
         send_pct = 0; recv_pct = 0;
      end
   endtask

   task automatic send_random(logic [1:0] kind, int f, int x);
      send(kind, f, x, sample_value(), sample_value(), sample_value(), sample_value());
   endtask

   // hold off until the core is empty
   task automatic drain();
      req_tvalid <= 0;
      wait (pending == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic run_phase(int nf, int nx, int m, int steps);
      drain();
      write_reg(CSR_NUM_FREQS, nf);
      write_reg(CSR_NUM_X, nx);
      write_reg(CSR_HALF_WIDTH, m);
      for (int f = 0; f < nf; f++)
         for (int x = 0; x < nx; x++)
            send_random(KIND_LOAD, f, x);
      for (int s = 0; s < steps; s++)
         for (int f = 0; f < nf; f++)
            for (int x = 0; x < nx; x++)
               for (int t = 0; t <= 2 * m; t++) begin
                  case ($urandom_range(19))
                     0: send_random(KIND_READ, $urandom_range(nf - 1), $urandom_range(nx - 1));
                     1: send_random(KIND_LOAD, $urandom_range(nf - 1), $urandom_range(nx - 1));
                     2: send_random(KIND_IGNORED, $urandom_range(255), $urandom_range(511));
                     default: ;
                  endcase
                  send_random(KIND_TAP, 0, 0);
               end
      for (int k = 0; k < 3; k++)
         send_random(KIND_READ, $urandom_range(nf - 1), $urandom_range(nx - 1));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_reg(CSR_NUM_FREQS, 1);
      write_reg(CSR_NUM_X, 1);
      write_reg(CSR_HALF_WIDTH, 0);
      send(KIND_LOAD, 255, 511, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h7fffffff);
      send(KIND_LOAD, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
      send(KIND_READ, 255, 511, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0, 0);
      send(KIND_IGNORED, 255, 511, '1, '1, '1, '1);
      send(KIND_TAP, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send(KIND_READ, 0, 0, 0, 0, 0, 0);
      send(KIND_LOAD, 0, 0, 32'h00800000, 32'hff800000, 32'h00800000, 32'h00800000);
      send(KIND_TAP, 0, 0, 32'h40000000, 32'h00000000, 32'h40000000, 32'hc0000000);
      send(KIND_TAP, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      run_phase(1, 1, 32, 1);
      run_phase(256, 1, 0, 1);
      run_phase(1, 512, 0, 1);
      run_phase(2, 3, 4, 2);
      while (item_cnt < 1800)
         run_phase($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(0, 4),
                   $urandom_range(1, 3));
      drain();
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
